// ----- src/incremental_weighted_line_fit_assert.svh -----
// ============================================================================
// Line fit assertion macros
// Shared concurrent assertion forms for the line fit block.
// ============================================================================
`ifndef INCREMENTAL_WEIGHTED_LINE_FIT_ASSERT_SVH
`define INCREMENTAL_WEIGHTED_LINE_FIT_ASSERT_SVH

// same-cycle implication
`define IWLF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IWLF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/iwlf_pkg.sv -----
// ============================================================================
// Line fit package
// Types, codes and constants shared by the line fit modules.
// ============================================================================
package iwlf_pkg;

    localparam int LIMB_W    = 32;
    localparam int MAC_A_W   = 160;
    localparam int MAC_B_W   = 96;
    localparam int ACC_W     = 192;
    localparam int DIV_W     = 160;
    localparam int QUOT_W    = 64;

    localparam logic [6:0]  TERM_STEPS  = 7'd63;
    localparam logic [6:0]  QDIV_STEPS  = 7'd32;
    localparam logic [65:0] SCALE_FLOOR = 66'd4294967;
    localparam logic [31:0] THR_RESET   = 32'd4295;

    typedef enum logic [1:0] {
        FIT_VALID    = 2'd0,
        FIT_FIRST    = 2'd1,
        FIT_SINGULAR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_TW,
        OP_TX,
        OP_TY,
        OP_TXX,
        OP_TXY,
        OP_DET0,
        OP_DET1,
        OP_SCALE,
        OP_SQ,
        OP_THR,
        OP_CHK,
        OP_NS0,
        OP_NS1,
        OP_QS,
        OP_NI0,
        OP_NI1,
        OP_QI,
        OP_DONE
    } t_op;

    typedef struct packed {
        logic               go;
        logic               clear;
        logic               neg;
        logic [2:0]         a_last;
        logic [1:0]         b_last;
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
    } t_mac_cmd;

    typedef struct packed {
        logic             go;
        logic [6:0]       steps;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
    } t_div_cmd;

endpackage

// ----- src/iwlf_mac.sv -----
// ============================================================================
// Line fit multiply-accumulate unit
// One 32x32 multiplier walks the limbs of two operands and adds or
// subtracts each partial product into a 192-bit accumulator.
// ============================================================================
module iwlf_mac (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  iwlf_pkg::t_mac_cmd      i_cmd,
    output logic                    o_done,
    output logic [iwlf_pkg::ACC_W-1:0] o_acc
);
    import iwlf_pkg::*;

    logic [MAC_A_W-1:0] r_a;
    logic [MAC_B_W-1:0] r_b;
    logic [2:0]         r_i;
    logic [1:0]         r_j;
    logic [2:0]         r_a_last;
    logic [1:0]         r_b_last;
    logic               r_neg;
    logic               r_busy;
    logic [63:0]        r_pp;
    logic [2:0]         r_k;
    logic               r_pp_neg;
    logic               r_pp_v;
    logic               r_pp_last;
    logic [ACC_W-1:0]   r_acc;
    logic               r_done;

    logic [LIMB_W-1:0]  w_a_limb;
    logic [LIMB_W-1:0]  w_b_limb;
    logic [ACC_W-1:0]   w_ext;
    logic               w_last;

    // limb select
    assign w_a_limb = r_a[{r_i, 5'b0} +: LIMB_W];
    assign w_b_limb = r_b[{r_j, 5'b0} +: LIMB_W];
    assign w_last   = (r_i == r_a_last) && (r_j == r_b_last);

    // place partial product at its limb weight
    always_comb begin
        case (r_k)
            3'd0:    w_ext = {128'b0, r_pp};
            3'd1:    w_ext = {96'b0, r_pp, 32'b0};
            3'd2:    w_ext = {64'b0, r_pp, 64'b0};
            3'd3:    w_ext = {32'b0, r_pp, 96'b0};
            3'd4:    w_ext = {r_pp, 128'b0};
            default: w_ext = '0;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pp_v    <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= r_pp_v && r_pp_last;
            r_pp_v <= r_busy;
            r_pp_last <= r_busy && w_last;
            if (i_cmd.go) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand walk and multiply stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_a      <= i_cmd.a;
            r_b      <= i_cmd.b;
            r_a_last <= i_cmd.a_last;
            r_b_last <= i_cmd.b_last;
            r_neg    <= i_cmd.neg;
            r_i      <= 3'd0;
            r_j      <= 2'd0;
        end else if (r_busy) begin
            if (r_j == r_b_last) begin
                r_j <= 2'd0;
                r_i <= r_i + 3'd1;
            end else begin
                r_j <= r_j + 2'd1;
            end
        end
        r_pp     <= w_a_limb * w_b_limb;
        r_k      <= r_i + {1'b0, r_j};
        r_pp_neg <= r_neg;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.go && i_cmd.clear) begin
            r_acc <= '0;
        end else if (r_pp_v) begin
            r_acc <= r_pp_neg ? (r_acc - w_ext) : (r_acc + w_ext);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ----- src/iwlf_div.sv -----
// ============================================================================
// Line fit divider
// Restoring divider, one quotient bit per cycle against a pre-shifted
// divisor that moves right one place per step.
// ============================================================================
module iwlf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  iwlf_pkg::t_div_cmd         i_cmd,
    output logic                       o_done,
    output logic [iwlf_pkg::QUOT_W-1:0] o_quot
);
    import iwlf_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic              w_ge;

    assign w_ge = r_rem >= r_den;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one compare and subtract per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_rem  <= i_cmd.rem;
            r_den  <= i_cmd.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (r_rem - r_den) : r_rem;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_den  <= {1'b0, r_den[DIV_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- src/incremental_weighted_line_fit.sv -----
// ============================================================================
// Incremental weighted line fit
// Accumulates weighted sums of points and solves for slope and intercept.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | i_in_valid/o_in_ready, point fields      | sink
//   out     | o_out_valid/i_out_ready, fit fields      | source
//   cfg     | i_cfg_valid/o_cfg_ready, i_cfg_data      | sink
//
// Every beat runs five weight divisions on the shared divider; a beat that
// does not start a fit then solves the fit, using the multiply-accumulate
// unit and two more quotient divisions on the same divider.
// Reset (synchronous, active low) clears the sums and loads the threshold.
// A finished result waits in the output register; the next beat is taken
// meanwhile and the sequencer only stalls at its end if that slot is full.
// ============================================================================
`include "incremental_weighted_line_fit_assert.svh"

module incremental_weighted_line_fit #(
    parameter int SUM_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic [15:0]        i_y_error,
    input  logic               i_start_fit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_slope,
    output logic signed [31:0] o_intercept,
    output logic [1:0]         o_fit_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import iwlf_pkg::*;

    localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1;
    localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;

    t_state                      r_state, n_state;
    t_op                         r_op, n_op;
    logic signed [15:0]          r_x, r_y;
    logic [15:0]                 r_e;
    logic                        r_start;
    logic [31:0]                 r_e2, r_xx, r_xy;
    logic signed [SUM_WIDTH-1:0] r_sum_w, r_sum_x, r_sum_xx, r_sum_y, r_sum_xy;
    logic [31:0]                 r_thr;
    logic [127:0]                r_dmag, r_nmag;
    logic                        r_dneg, r_dzero, r_nneg;
    logic [65:0]                 r_scale;
    logic [31:0]                 r_slope, r_intercept;
    t_status                     r_status;
    logic                        r_out_valid;
    logic [31:0]                 r_o_slope, r_o_intercept;
    t_status                     r_o_status;

    t_mac_cmd                    w_mac_cmd;
    t_div_cmd                    w_div_cmd;
    logic                        w_mac_done, w_div_done;
    logic [ACC_W-1:0]            w_acc;
    logic [QUOT_W-1:0]           w_quot;
    logic                        w_is_div, w_is_mac, w_unit_done;
    logic [15:0]                 w_ax, w_ay;
    logic [63:0]                 w_m_w, w_m_x, w_m_xx, w_m_y, w_m_xy;
    logic                        w_n_w, w_n_x, w_n_xx, w_n_y, w_n_xy;
    logic [63:0]                 w_num;
    logic                        w_tneg;
    logic signed [63:0]          w_term;
    logic                        w_acc_neg;
    logic [ACC_W-1:0]            w_acc_mag;
    logic [65:0]                 w_scale_sum;
    logic                        w_singular;
    logic                        w_in_acc, w_out_free;

    // saturating accumulate into a sum
    function automatic logic signed [SUM_WIDTH-1:0] f_sat_add(
        input logic signed [SUM_WIDTH-1:0] s,
        input logic signed [63:0]          t
    );
        logic signed [65:0] v;
        v = 66'(s) + 66'(t);
        if (v > SUM_MAX) begin
            return SUM_WIDTH'(SUM_MAX);
        end else if (v < SUM_MIN) begin
            return SUM_WIDTH'(SUM_MIN);
        end
        return SUM_WIDTH'(v);
    endfunction

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // signed, saturated Q16.16 result from quotient magnitude
    function automatic logic [31:0] f_fmt(input logic [31:0] q, input logic neg);
        if (q[31]) begin
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return neg ? (~q + 32'd1) : q;
    endfunction

    // shared units
    iwlf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    iwlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // operand magnitudes and signs
    assign w_ax   = r_x[15] ? (~r_x + 16'd1) : r_x;
    assign w_ay   = r_y[15] ? (~r_y + 16'd1) : r_y;
    assign w_m_w  = f_mag(64'(r_sum_w));
    assign w_m_x  = f_mag(64'(r_sum_x));
    assign w_m_xx = f_mag(64'(r_sum_xx));
    assign w_m_y  = f_mag(64'(r_sum_y));
    assign w_m_xy = f_mag(64'(r_sum_xy));
    assign w_n_w  = r_sum_w[SUM_WIDTH-1];
    assign w_n_x  = r_sum_x[SUM_WIDTH-1];
    assign w_n_xx = r_sum_xx[SUM_WIDTH-1];
    assign w_n_y  = r_sum_y[SUM_WIDTH-1];
    assign w_n_xy = r_sum_xy[SUM_WIDTH-1];

    assign w_is_div = r_op inside {OP_TW, OP_TX, OP_TY, OP_TXX, OP_TXY, OP_QS, OP_QI};
    assign w_is_mac = r_op inside {OP_DET0, OP_DET1, OP_SQ, OP_THR,
                                   OP_NS0, OP_NS1, OP_NI0, OP_NI1};
    assign w_unit_done = w_is_div ? w_div_done : w_mac_done;

    // weight term numerator and sign
    always_comb begin
        case (r_op)
            OP_TW:   begin w_num = 64'd1 << 48;              w_tneg = 1'b0; end
            OP_TX:   begin w_num = {8'b0, w_ax, 40'b0};      w_tneg = r_x[15]; end
            OP_TY:   begin w_num = {8'b0, w_ay, 40'b0};      w_tneg = r_y[15]; end
            OP_TXX:  begin w_num = {r_xx, 32'b0};            w_tneg = 1'b0; end
            OP_TXY:  begin w_num = {r_xy, 32'b0};            w_tneg = r_x[15] ^ r_y[15]; end
            default: begin w_num = '0;                       w_tneg = 1'b0; end
        endcase
    end

    assign w_term      = w_tneg ? -$signed(w_quot) : $signed(w_quot);
    assign w_acc_neg   = w_acc[ACC_W-1];
    assign w_acc_mag   = w_acc_neg ? (~w_acc + 1'b1) : w_acc;
    assign w_scale_sum = 66'(w_m_x) + 66'(w_m_xx) + 66'(w_m_w);
    assign w_singular  = r_dzero || ({32'b0, r_dmag, 32'b0} < w_acc);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // next state and next op
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_PREP;
                    n_op    = OP_TW;
                end
            end
            ST_PREP: n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (r_op == OP_DONE) begin
                    n_state = ST_FINISH;
                end else if (w_is_div || w_is_mac) begin
                    n_state = ST_WAIT;
                end else if (r_op == OP_CHK && w_singular) begin
                    n_op = OP_DONE;
                end else begin
                    n_op = t_op'(r_op + 5'd1);
                end
            end
            ST_WAIT: begin
                if (w_unit_done) begin
                    n_state = ST_ISSUE;
                    n_op    = (r_op == OP_TXY && r_start) ? OP_DONE : t_op'(r_op + 5'd1);
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // unit commands
    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        w_mac_cmd        = '0;
        w_div_cmd        = '0;
        w_mac_cmd.go     = (r_state == ST_ISSUE) && w_is_mac;
        w_div_cmd.go     = (r_state == ST_ISSUE) && w_is_div;
        w_mac_cmd.a_last = 3'd1;
        w_mac_cmd.b_last = 2'd1;
        w_mac_cmd.clear  = 1'b1;
        case (r_op)
            OP_DET0: begin
                w_mac_cmd.a   = {96'b0, w_m_xx};
                w_mac_cmd.b   = {32'b0, w_m_w};
                w_mac_cmd.neg = w_n_xx ^ w_n_w;
            end
            OP_DET1: begin
                w_mac_cmd.a     = {96'b0, w_m_x};
                w_mac_cmd.b     = {32'b0, w_m_x};
                w_mac_cmd.neg   = 1'b1;
                w_mac_cmd.clear = 1'b0;
            end
            OP_SQ: begin
                w_mac_cmd.a      = {94'b0, r_scale};
                w_mac_cmd.b      = {30'b0, r_scale};
                w_mac_cmd.a_last = 3'd2;
                w_mac_cmd.b_last = 2'd2;
            end
            OP_THR: begin
                w_mac_cmd.a      = w_acc[MAC_A_W-1:0];
                w_mac_cmd.b      = {64'b0, r_thr};
                w_mac_cmd.a_last = 3'd4;
                w_mac_cmd.b_last = 2'd0;
            end
            OP_NS0: begin
                w_mac_cmd.a   = {96'b0, w_m_w};
                w_mac_cmd.b   = {32'b0, w_m_xy};
                w_mac_cmd.neg = w_n_w ^ w_n_xy;
            end
            OP_NS1: begin
                w_mac_cmd.a     = {96'b0, w_m_x};
                w_mac_cmd.b     = {32'b0, w_m_y};
                w_mac_cmd.neg   = !(w_n_x ^ w_n_y);
                w_mac_cmd.clear = 1'b0;
            end
            OP_NI0: begin
                w_mac_cmd.a   = {96'b0, w_m_xx};
                w_mac_cmd.b   = {32'b0, w_m_y};
                w_mac_cmd.neg = w_n_xx ^ w_n_y;
            end
            OP_NI1: begin
                w_mac_cmd.a     = {96'b0, w_m_x};
                w_mac_cmd.b     = {32'b0, w_m_xy};
                w_mac_cmd.neg   = !(w_n_x ^ w_n_xy);
                w_mac_cmd.clear = 1'b0;
            end
            OP_QS, OP_QI: begin
                w_div_cmd.rem   = {16'b0, r_nmag, 16'b0};
                w_div_cmd.den   = {1'b0, r_dmag, 31'b0};
                w_div_cmd.steps = QDIV_STEPS;
            end
            default: begin
                w_div_cmd.rem   = {96'b0, w_num};
                w_div_cmd.den   = {66'b0, r_e2, 62'b0};
                w_div_cmd.steps = TERM_STEPS;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_TW;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_sum_w     <= '0;
            r_sum_x     <= '0;
            r_sum_xx    <= '0;
            r_sum_y     <= '0;
            r_sum_xy    <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            // output slot
            if (r_state == ST_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // running sums
            if (r_state == ST_WAIT && w_div_done) begin
                case (r_op)
                    OP_TW:   r_sum_w  <= f_sat_add(r_start ? '0 : r_sum_w, w_term);
                    OP_TX:   r_sum_x  <= f_sat_add(r_start ? '0 : r_sum_x, w_term);
                    OP_TY:   r_sum_y  <= f_sat_add(r_start ? '0 : r_sum_y, w_term);
                    OP_TXX:  r_sum_xx <= f_sat_add(r_start ? '0 : r_sum_xx, w_term);
                    OP_TXY:  r_sum_xy <= f_sat_add(r_start ? '0 : r_sum_xy, w_term);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x     <= i_point_x;
            r_y     <= i_point_y;
            r_e     <= (i_y_error == 16'd0) ? 16'd1 : i_y_error;
            r_start <= i_start_fit;
        end
        if (r_state == ST_PREP) begin
            r_e2        <= r_e * r_e;
            r_xx        <= w_ax * w_ax;
            r_xy        <= w_ax * w_ay;
            r_slope     <= '0;
            r_intercept <= '0;
            r_status    <= r_start ? FIT_FIRST : FIT_VALID;
        end
        if (r_state == ST_ISSUE && r_op == OP_SCALE) begin
            r_scale <= (w_scale_sum <= SCALE_FLOOR) ? (66'd1 << 32) : w_scale_sum;
        end
        if (r_state == ST_ISSUE && r_op == OP_CHK && w_singular) begin
            r_status <= FIT_SINGULAR;
        end
        if (r_state == ST_WAIT && w_unit_done) begin
            case (r_op)
                OP_DET1: begin
                    r_dneg  <= w_acc_neg;
                    r_dmag  <= w_acc_mag[127:0];
                    r_dzero <= (w_acc == '0);
                end
                OP_NS1, OP_NI1: begin
                    r_nneg <= w_acc_neg;
                    r_nmag <= w_acc_mag[127:0];
                end
                OP_QS:   r_slope     <= f_fmt(w_quot[31:0], r_nneg ^ r_dneg);
                OP_QI:   r_intercept <= f_fmt(w_quot[31:0], r_nneg ^ r_dneg);
                default: ;
            endcase
        end
        if (r_state == ST_FINISH && w_out_free) begin
            r_o_slope     <= r_slope;
            r_o_intercept <= r_intercept;
            r_o_status    <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slope      = r_o_slope;
    assign o_intercept  = r_o_intercept;
    assign o_fit_status = r_o_status;
    assign o_cfg_ready  = 1'b1;

    // checks
    `IWLF_ASSERT_NXT(a_accept_prep, i_clk, i_rst_n, w_in_acc, r_state == ST_PREP, "beat accept did not start prep")
    `IWLF_ASSERT_IMP(a_one_unit, i_clk, i_rst_n, w_mac_cmd.go, !w_div_cmd.go, "both units started together")
    `IWLF_ASSERT_IMP(a_zero_fit, i_clk, i_rst_n, o_out_valid && (o_fit_status != FIT_VALID), (o_slope == 0) && (o_intercept == 0), "nonzero fit on non-valid status")
    `IWLF_ASSERT_IMP(a_out_load, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == ST_FINISH), "result appeared outside finish")

endmodule
